// ----- design/ubxfr_pkg.sv -----
`timescale 1ns / 1ps
package ubxfr_pkg;

  localparam int unsigned POSITION_PAYLOAD_BYTES = 92;
  localparam int unsigned ACK_PAYLOAD_BYTES = 2;

  localparam logic [7:0] SYNC_ONE = 8'hB5;
  localparam logic [7:0] SYNC_TWO = 8'h62;

  localparam logic [15:0] ID_NAV_PVT = 16'h0701;
  localparam logic [15:0] ID_ACK_ACK = 16'h0105;
  localparam logic [15:0] ID_ACK_NAK = 16'h0005;

  localparam int unsigned CAP_W = 32;
  localparam int unsigned CAP_DEPTH = 9;
  localparam int unsigned CAP_AW = $clog2(CAP_DEPTH);

  typedef logic [CAP_AW-1:0] cap_addr_t;

  localparam cap_addr_t ADDR_SMALL = cap_addr_t'(0);
  localparam cap_addr_t ADDR_LON = cap_addr_t'(1);
  localparam cap_addr_t ADDR_LAT = cap_addr_t'(2);
  localparam cap_addr_t ADDR_HEIGHT = cap_addr_t'(3);
  localparam cap_addr_t ADDR_VEL_N = cap_addr_t'(4);
  localparam cap_addr_t ADDR_VEL_E = cap_addr_t'(5);
  localparam cap_addr_t ADDR_VEL_D = cap_addr_t'(6);
  localparam cap_addr_t ADDR_DECL = cap_addr_t'(7);
  localparam cap_addr_t ADDR_ACK = cap_addr_t'(8);

  typedef enum logic [2:0] {
    KIND_POSITION  = 3'd0,
    KIND_ACK_MATCH = 3'd1,
    KIND_ACK_OTHER = 3'd2,
    KIND_NAK_MATCH = 3'd3,
    KIND_NAK_OTHER = 3'd4
  } frame_kind_t;

  localparam int unsigned CFG_W = 16;
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CONFIGURED = 2'd0;
  localparam cfg_idx_t REG_ACK_ARMED = 2'd1;
  localparam cfg_idx_t REG_AWAITED_ID = 2'd2;

  typedef struct packed {
    logic             we;
    cap_addr_t        addr;
    logic [CAP_W-1:0] data;
  } cap_wr_t;

  typedef struct packed {
    logic        fin_vld;
    logic [15:0] fin_msg_id;
    logic        at_ck2;
  } prs_status_t;

endpackage

// ----- design/ubxfr_ram.sv -----
`timescale 1ns / 1ps
module ubxfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- design/ubxfr_parser.sv -----
`timescale 1ns / 1ps
module ubxfr_parser import ubxfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_accept,
  input  logic [7:0]  in_byte,
  input  logic        cfg_configured,
  output cap_wr_t     cap_wr,
  output prs_status_t status
);

  localparam logic [6:0] OFS_SMALL_END = 7'd23;
  localparam logic [6:0] OFS_LON_END = 7'd27;
  localparam logic [6:0] OFS_LAT_END = 7'd31;
  localparam logic [6:0] OFS_HEIGHT_END = 7'd39;
  localparam logic [6:0] OFS_VEL_N_END = 7'd51;
  localparam logic [6:0] OFS_VEL_E_END = 7'd55;
  localparam logic [6:0] OFS_VEL_D_END = 7'd59;
  localparam logic [6:0] OFS_DECL_END = 7'd89;
  localparam logic [6:0] OFS_ACK_END = 7'd1;
  localparam logic [6:0] POS_MAX = 7'd127;

  typedef enum logic [3:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN1,
    PH_LEN2,
    PH_PAYLOAD,
    PH_CK1,
    PH_CK2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [15:0] msg_id_r, msg_id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic        handled_r, handled_nxt;
  logic [31:0] shift_r, shift_nxt;
  cap_wr_t     wr_r, wr_nxt;
  logic        fin_vld_r, fin_vld_nxt;
  logic [15:0] fin_msg_r, fin_msg_nxt;

  logic [7:0]  sum_a_add;
  logic [7:0]  sum_b_add;
  logic [15:0] len_full;

  assign sum_a_add = sum_a_r + in_byte;
  assign sum_b_add = sum_b_r + sum_a_add;
  assign len_full = {in_byte, len_r[7:0]};

  always_comb begin
    logic do_restart;
    logic reject;
    logic is_nav;
    logic is_ack;
    do_restart = 1'b0;
    reject = 1'b0;
    is_nav = (msg_id_r == ID_NAV_PVT);
    is_ack = (msg_id_r == ID_ACK_ACK) || (msg_id_r == ID_ACK_NAK);
    phase_nxt = phase_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    msg_id_nxt = msg_id_r;
    len_nxt = len_r;
    pos_nxt = pos_r;
    handled_nxt = handled_r;
    shift_nxt = shift_r;
    wr_nxt.we = 1'b0;
    wr_nxt.addr = ADDR_SMALL;
    wr_nxt.data = shift_r;
    fin_vld_nxt = 1'b0;
    fin_msg_nxt = fin_msg_r;
    if (in_accept) begin
      unique case (phase_r)
        PH_SYNC1: begin
          if (in_byte == SYNC_ONE) begin
            phase_nxt = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          if (in_byte == SYNC_TWO) begin
            phase_nxt = PH_CLASS;
          end else begin
            do_restart = 1'b1;
          end
        end
        PH_CLASS: begin
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          msg_id_nxt = {8'h00, in_byte};
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          msg_id_nxt = {in_byte, msg_id_r[7:0]};
          phase_nxt = PH_LEN1;
        end
        PH_LEN1: begin
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          len_nxt = {8'h00, in_byte};
          phase_nxt = PH_LEN2;
        end
        PH_LEN2: begin
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          len_nxt = len_full;
          if (is_nav) begin
            if (!cfg_configured) begin
              handled_nxt = 1'b0;
            end else if (len_full != 16'(POSITION_PAYLOAD_BYTES)) begin
              reject = 1'b1;
            end else begin
              handled_nxt = 1'b1;
            end
          end else if (is_ack) begin
            if (len_full != 16'(ACK_PAYLOAD_BYTES)) begin
              reject = 1'b1;
            end else begin
              handled_nxt = !cfg_configured;
            end
          end else begin
            reject = 1'b1;
          end
          if (reject) begin
            do_restart = 1'b1;
          end else begin
            pos_nxt = '0;
            phase_nxt = (len_full != 16'd0) ? PH_PAYLOAD : PH_CK1;
          end
        end
        PH_PAYLOAD: begin
          sum_a_nxt = sum_a_add;
          sum_b_nxt = sum_b_add;
          shift_nxt = {in_byte, shift_r[31:8]};
          if (handled_r) begin
            if (is_nav) begin
              wr_nxt.data = shift_nxt;
              case (pos_r)
                OFS_SMALL_END: begin
                  wr_nxt.we = 1'b1;
                  wr_nxt.addr = ADDR_SMALL;
                end
                OFS_LON_END: begin
                  wr_nxt.we = 1'b1;
                  wr_nxt.addr = ADDR_LON;
                end
                OFS_LAT_END: begin
                  wr_nxt.we = 1'b1;
                  wr_nxt.addr = ADDR_LAT;
                end
                OFS_HEIGHT_END: begin
                  wr_nxt.we = 1'b1;
                  wr_nxt.addr = ADDR_HEIGHT;
                end
                OFS_VEL_N_END: begin
                  wr_nxt.we = 1'b1;
                  wr_nxt.addr = ADDR_VEL_N;
                end
                OFS_VEL_E_END: begin
                  wr_nxt.we = 1'b1;
                  wr_nxt.addr = ADDR_VEL_E;
                end
                OFS_VEL_D_END: begin
                  wr_nxt.we = 1'b1;
                  wr_nxt.addr = ADDR_VEL_D;
                end
                OFS_DECL_END: begin
                  wr_nxt.we = 1'b1;
                  wr_nxt.addr = ADDR_DECL;
                  wr_nxt.data = {16'h0000, shift_nxt[31:16]};
                end
                default: begin
                end
              endcase
            end else if (pos_r == OFS_ACK_END) begin
              wr_nxt.we = 1'b1;
              wr_nxt.addr = ADDR_ACK;
              wr_nxt.data = {16'h0000, shift_nxt[31:16]};
            end
          end
          if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + 7'd1;
          end
          len_nxt = len_r - 16'd1;
          if (len_r == 16'd1) begin
            phase_nxt = PH_CK1;
          end
        end
        PH_CK1: begin
          if (in_byte != sum_a_r) begin
            do_restart = 1'b1;
          end else begin
            phase_nxt = PH_CK2;
          end
        end
        PH_CK2: begin
          if (in_byte == sum_b_r && handled_r) begin
            fin_vld_nxt = 1'b1;
            fin_msg_nxt = msg_id_r;
          end
          do_restart = 1'b1;
        end
        default: begin
          do_restart = 1'b1;
        end
      endcase
    end
    if (do_restart) begin
      phase_nxt = PH_SYNC1;
      sum_a_nxt = '0;
      sum_b_nxt = '0;
      msg_id_nxt = '0;
      len_nxt = '0;
      pos_nxt = '0;
      handled_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      sum_a_r <= '0;
      sum_b_r <= '0;
      msg_id_r <= '0;
      len_r <= '0;
      pos_r <= '0;
      handled_r <= 1'b0;
      wr_r.we <= 1'b0;
      fin_vld_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      msg_id_r <= msg_id_nxt;
      len_r <= len_nxt;
      pos_r <= pos_nxt;
      handled_r <= handled_nxt;
      wr_r.we <= wr_nxt.we;
      fin_vld_r <= fin_vld_nxt;
    end
    shift_r <= shift_nxt;
    wr_r.addr <= wr_nxt.addr;
    wr_r.data <= wr_nxt.data;
    fin_msg_r <= fin_msg_nxt;
  end

  assign cap_wr = wr_r;
  assign status.fin_vld = fin_vld_r;
  assign status.fin_msg_id = fin_msg_r;
  assign status.at_ck2 = (phase_r == PH_CK2);

endmodule

// ----- design/ubx_frame_receiver_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit first)                               tuser
// in_       slave      rx_byte                                             -
// out_      master     message_id, fix_type, fix_flags, satellite_count,   frame_kind
//                      longitude, latitude, height_msl, velocity_north,
//                      velocity_east, velocity_down, magnetic_declination
// cfg_      write      index 0 configured, 1 ack armed, 2 awaited id       -
//
// The parser takes one byte every cycle in which in_tvalid and in_tready are both high.
// A good frame's result becomes valid once its captured words have been read out of the
// capture memory, one word for an acknowledgement and eight for a position frame, each
// passing the read and pending registers before the result registers are loaded.
// in_tready drops only on a second checksum byte while the previous result is still
// being read out or waits in the output register. Reset is synchronous and needs
// no clearing pass; a result is read only from words its own frame has written.
module ubx_frame_receiver_core import ubxfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,    // rx_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [247:0]     out_tdata,   // message_id, fix_type, fix_flags, satellite_count,
                                        // longitude, latitude, height_msl, velocity_north,
                                        // velocity_east, velocity_down, magnetic_declination
  output logic [2:0]       out_tuser,   // frame_kind
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  logic        cfg_configured_r;
  logic        cfg_ack_armed_r;
  logic [15:0] cfg_awaited_r;

  logic        in_accept;
  cap_wr_t     cap_wr;
  prs_status_t prs_st;
  logic [CAP_W-1:0] ram_rdata;

  logic        rd_act_r;
  cap_addr_t   rd_addr_r;
  logic        pend_vld_r;
  cap_addr_t   pend_addr_r;
  logic        out_tvalid_r;
  logic        res_busy;
  logic        ack_match;

  logic [15:0]        res_msg_r;
  frame_kind_t        kind_r;
  logic [7:0]         fix_type_r;
  logic [7:0]         fix_flags_r;
  logic [7:0]         sat_count_r;
  logic signed [31:0] lon_r;
  logic signed [31:0] lat_r;
  logic signed [31:0] height_r;
  logic signed [31:0] vel_n_r;
  logic signed [31:0] vel_e_r;
  logic signed [31:0] vel_d_r;
  logic signed [15:0] decl_r;

  assign res_busy = prs_st.fin_vld | rd_act_r | pend_vld_r | out_tvalid_r;
  assign in_tready = !(prs_st.at_ck2 && res_busy);
  assign in_accept = in_tvalid && in_tready;

  ubxfr_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_byte        (in_tdata),
    .cfg_configured (cfg_configured_r),
    .cap_wr         (cap_wr),
    .status         (prs_st)
  );

  ubxfr_ram #(
    .WIDTH (CAP_W),
    .DEPTH (CAP_DEPTH)
  ) u_cap_ram (
    .clk   (clk),
    .we    (cap_wr.we),
    .waddr (cap_wr.addr),
    .wdata (cap_wr.data),
    .re    (rd_act_r),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_configured_r <= 1'b0;
      cfg_ack_armed_r <= 1'b0;
      cfg_awaited_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CONFIGURED: cfg_configured_r <= cfg_wdata[0];
        REG_ACK_ARMED:  cfg_ack_armed_r <= cfg_wdata[0];
        REG_AWAITED_ID: cfg_awaited_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r <= 1'b0;
      rd_addr_r <= ADDR_SMALL;
      pend_vld_r <= 1'b0;
      pend_addr_r <= ADDR_SMALL;
      out_tvalid_r <= 1'b0;
    end else begin
      pend_vld_r <= rd_act_r;
      pend_addr_r <= rd_addr_r;
      if (prs_st.fin_vld) begin
        rd_act_r <= 1'b1;
        rd_addr_r <= (prs_st.fin_msg_id == ID_NAV_PVT) ? ADDR_SMALL : ADDR_ACK;
      end else if (rd_act_r) begin
        rd_addr_r <= rd_addr_r + cap_addr_t'(1);
        if (rd_addr_r == ADDR_DECL || rd_addr_r == ADDR_ACK) begin
          rd_act_r <= 1'b0;
        end
      end
      if (pend_vld_r && (pend_addr_r == ADDR_DECL || pend_addr_r == ADDR_ACK)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign ack_match = cfg_ack_armed_r && (ram_rdata[15:0] == cfg_awaited_r);

  always_ff @(posedge clk) begin
    if (prs_st.fin_vld) begin
      res_msg_r <= prs_st.fin_msg_id;
      fix_type_r <= '0;
      fix_flags_r <= '0;
      sat_count_r <= '0;
      lon_r <= '0;
      lat_r <= '0;
      height_r <= '0;
      vel_n_r <= '0;
      vel_e_r <= '0;
      vel_d_r <= '0;
      decl_r <= '0;
    end
    if (pend_vld_r) begin
      case (pend_addr_r)
        ADDR_SMALL: begin
          fix_type_r <= ram_rdata[7:0];
          fix_flags_r <= ram_rdata[15:8];
          sat_count_r <= ram_rdata[31:24];
        end
        ADDR_LON:    lon_r <= ram_rdata;
        ADDR_LAT:    lat_r <= ram_rdata;
        ADDR_HEIGHT: height_r <= ram_rdata;
        ADDR_VEL_N:  vel_n_r <= ram_rdata;
        ADDR_VEL_E:  vel_e_r <= ram_rdata;
        ADDR_VEL_D:  vel_d_r <= ram_rdata;
        ADDR_DECL: begin
          decl_r <= ram_rdata[15:0];
          kind_r <= KIND_POSITION;
        end
        ADDR_ACK: begin
          if (res_msg_r == ID_ACK_ACK) begin
            kind_r <= ack_match ? KIND_ACK_MATCH : KIND_ACK_OTHER;
          end else begin
            kind_r <= ack_match ? KIND_NAK_MATCH : KIND_NAK_OTHER;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser = kind_r;
  assign out_tdata = {decl_r, vel_d_r, vel_e_r, vel_n_r, height_r, lat_r, lon_r,
                      sat_count_r, fix_flags_r, fix_type_r, res_msg_r};

endmodule

// ----- design/ubxfr_checker.sv -----
`timescale 1ns / 1ps
module ubxfr_checker import ubxfr_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [247:0] out_tdata,
  input logic [2:0]   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("Result changed or vanished while stalled.");

  a_pos_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_POSITION |-> out_tdata[15:0] == ID_NAV_PVT)
    else $error("Position result without a position message id.");

  a_ack_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_POSITION |->
      out_tdata[15:0] == ID_ACK_ACK || out_tdata[15:0] == ID_ACK_NAK)
    else $error("Acknowledge result with a foreign message id.");

  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_POSITION |-> out_tdata[247:16] == '0)
    else $error("Acknowledge result carries position data.");

  a_kind_vs_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15:0] == ID_ACK_ACK |->
      out_tuser == KIND_ACK_MATCH || out_tuser == KIND_ACK_OTHER)
    else $error("Ack frame reported with a nak or position kind.");

endmodule

bind ubx_frame_receiver_core ubxfr_checker u_ubxfr_checker (.*);

// ----- dv/ubx_frame_checker.sv -----
`timescale 1ns / 1ps
module ubx_frame_checker import ubxfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [247:0]     out_tdata,
  input  logic [2:0]       out_tuser,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               results_pending,
  output logic             parser_idle
);

  typedef enum logic [3:0] {
    PH_SYNC1, PH_SYNC2, PH_CLASS, PH_ID, PH_LEN1, PH_LEN2, PH_PAYLOAD, PH_CK1, PH_CK2
  } parse_phase_t;

  typedef struct {
    frame_kind_t kind;
    logic [15:0] msg_id;
    logic [7:0]  fix_type;
    logic [7:0]  fix_flags;
    logic [7:0]  sats;
    logic [31:0] lon;
    logic [31:0] lat;
    logic [31:0] height;
    logic [31:0] vel_n;
    logic [31:0] vel_e;
    logic [31:0] vel_d;
    logic [15:0] decl;
  } frame_result_t;

  localparam int WIDE_OFFSET [6] = '{24, 28, 36, 48, 52, 56};
  localparam int SMALL_OFFSET [3] = '{20, 21, 23};

  parse_phase_t  phase;
  logic [7:0]    sum_a, sum_b;
  logic [15:0]   msg_id;
  logic [15:0]   remaining;
  logic [6:0]    pos;
  logic          handled;
  logic [31:0]   wide [6];
  logic [7:0]    small_fields [3];
  logic [15:0]   decl;
  logic [15:0]   ack_id;

  logic          cfg_configured;
  logic          cfg_armed;
  logic [15:0]   cfg_awaited;

  frame_result_t expected_frames [$];

  assign parser_idle = (phase == PH_SYNC1);

  task automatic restart_parser();
    phase = PH_SYNC1;
    sum_a = '0;
    sum_b = '0;
    msg_id = '0;
    remaining = '0;
    pos = '0;
    handled = 1'b0;
  endtask

  task automatic fold_sum(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endtask

  task automatic capture_byte(input logic [6:0] at, input logic [7:0] b);
    int p;
    p = int'(at);
    if (msg_id == ID_NAV_PVT) begin
      for (int i = 0; i < 6; i++) begin
        if (p >= WIDE_OFFSET[i] && p < WIDE_OFFSET[i] + 4)
          wide[i][8*(p-WIDE_OFFSET[i]) +: 8] = b;
      end
      for (int i = 0; i < 3; i++) begin
        if (p == SMALL_OFFSET[i])
          small_fields[i] = b;
      end
      if (p == 88)
        decl[7:0] = b;
      if (p == 89)
        decl[15:8] = b;
    end else begin
      if (p == 0)
        ack_id[7:0] = b;
      if (p == 1)
        ack_id[15:8] = b;
    end
  endtask

  function automatic frame_result_t completed_frame();
    frame_result_t r;
    logic match;
    r.kind = KIND_POSITION;
    r.msg_id = msg_id;
    r.fix_type = '0;
    r.fix_flags = '0;
    r.sats = '0;
    r.lon = '0;
    r.lat = '0;
    r.height = '0;
    r.vel_n = '0;
    r.vel_e = '0;
    r.vel_d = '0;
    r.decl = '0;
    if (msg_id == ID_NAV_PVT) begin
      r.fix_type = small_fields[0];
      r.fix_flags = small_fields[1];
      r.sats = small_fields[2];
      r.lon = wide[0];
      r.lat = wide[1];
      r.height = wide[2];
      r.vel_n = wide[3];
      r.vel_e = wide[4];
      r.vel_d = wide[5];
      r.decl = decl;
    end else begin
      match = cfg_armed && (ack_id == cfg_awaited);
      if (msg_id == ID_ACK_ACK)
        r.kind = match ? KIND_ACK_MATCH : KIND_ACK_OTHER;
      else
        r.kind = match ? KIND_NAK_MATCH : KIND_NAK_OTHER;
    end
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    logic reject;
    reject = 1'b0;
    case (phase)
      PH_SYNC1: begin
        if (b == SYNC_ONE)
          phase = PH_SYNC2;
      end
      PH_SYNC2: begin
        if (b == SYNC_TWO)
          phase = PH_CLASS;
        else
          restart_parser();
      end
      PH_CLASS: begin
        fold_sum(b);
        msg_id = {8'h00, b};
        phase = PH_ID;
      end
      PH_ID: begin
        fold_sum(b);
        msg_id[15:8] = b;
        phase = PH_LEN1;
      end
      PH_LEN1: begin
        fold_sum(b);
        remaining = {8'h00, b};
        phase = PH_LEN2;
      end
      PH_LEN2: begin
        fold_sum(b);
        remaining[15:8] = b;
        if (msg_id == ID_NAV_PVT) begin
          if (!cfg_configured)
            handled = 1'b0;
          else if (remaining != 16'(POSITION_PAYLOAD_BYTES))
            reject = 1'b1;
          else
            handled = 1'b1;
        end else if (msg_id == ID_ACK_ACK || msg_id == ID_ACK_NAK) begin
          if (remaining != 16'(ACK_PAYLOAD_BYTES))
            reject = 1'b1;
          else
            handled = !cfg_configured;
        end else begin
          reject = 1'b1;
        end
        if (reject) begin
          restart_parser();
        end else begin
          pos = '0;
          phase = (remaining != 16'd0) ? PH_PAYLOAD : PH_CK1;
        end
      end
      PH_PAYLOAD: begin
        fold_sum(b);
        if (handled)
          capture_byte(pos, b);
        if (pos != 7'd127)
          pos = pos + 7'd1;
        remaining = remaining - 16'd1;
        if (remaining == 16'd0)
          phase = PH_CK1;
      end
      PH_CK1: begin
        if (b != sum_a)
          restart_parser();
        else
          phase = PH_CK2;
      end
      PH_CK2: begin
        if (b == sum_b && handled)
          expected_frames.push_back(completed_frame());
        restart_parser();
      end
      default: begin
        restart_parser();
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result();
    frame_result_t want;
    if (expected_frames.size() == 0) begin
      $display("%0t: result transaction with none expected: kind %0d id %h",
               $time, out_tuser, out_tdata[15:0]);
      mismatches++;
    end else begin
      want = expected_frames.pop_front();
      check_field("frame_kind", 32'(want.kind), 32'(out_tuser));
      check_field("message_id", 32'(want.msg_id), 32'(out_tdata[15:0]));
      check_field("fix_type", 32'(want.fix_type), 32'(out_tdata[23:16]));
      check_field("fix_flags", 32'(want.fix_flags), 32'(out_tdata[31:24]));
      check_field("satellite_count", 32'(want.sats), 32'(out_tdata[39:32]));
      check_field("longitude", want.lon, out_tdata[71:40]);
      check_field("latitude", want.lat, out_tdata[103:72]);
      check_field("height_msl", want.height, out_tdata[135:104]);
      check_field("velocity_north", want.vel_n, out_tdata[167:136]);
      check_field("velocity_east", want.vel_e, out_tdata[199:168]);
      check_field("velocity_down", want.vel_d, out_tdata[231:200]);
      check_field("magnetic_declination", 32'(want.decl), 32'(out_tdata[247:232]));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_parser();
      for (int i = 0; i < 6; i++)
        wide[i] = '0;
      for (int i = 0; i < 3; i++)
        small_fields[i] = '0;
      decl = '0;
      ack_id = '0;
      cfg_configured = 1'b0;
      cfg_armed = 1'b0;
      cfg_awaited = '0;
      expected_frames.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready)
        compare_result();
      if (cfg_we) begin
        case (cfg_idx)
          REG_CONFIGURED: cfg_configured = cfg_wdata[0];
          REG_ACK_ARMED: cfg_armed = cfg_wdata[0];
          REG_AWAITED_ID: cfg_awaited = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        parse_byte(in_tdata);
    end
    results_pending = expected_frames.size();
  end

endmodule

// ----- dv/tb_ubx_frame_receiver_core.sv -----
`timescale 1ns / 1ps
module tb_ubx_frame_receiver_core;
  import ubxfr_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int MIN_BYTES = 1800;
  localparam int DRAIN_CYCLES = 12;

  typedef enum int {FLAW_NONE, FLAW_SYNC, FLAW_CKA, FLAW_CKB} flaw_t;
  typedef enum int {BODY_RANDOM, BODY_ZERO, BODY_ONES} body_style_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [247:0]     out_tdata;
  logic [2:0]       out_tuser;
  logic             cfg_we;
  cfg_idx_t         cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  int               mismatches;
  int               results_pending;
  logic             parser_idle;

  logic             steady;
  logic [15:0]      awaited;
  int               bytes_sent;
  logic [7:0]       body_q [$];

  always #10 clk = ~clk;

  ubx_frame_receiver_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  ubx_frame_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .results_pending (results_pending),
    .parser_idle     (parser_idle)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady)
      return 0;
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int hold;
    int gap;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      hold = $urandom_range(1, 8);
      out_tready <= 1'b1;
      repeat (hold) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic set_config(input logic configured, input logic armed,
                            input logic [15:0] awaited_id);
    cfg_we <= 1'b1;
    cfg_idx <= REG_CONFIGURED;
    cfg_wdata <= {15'($urandom), configured};
    @(negedge clk);
    cfg_idx <= REG_ACK_ARMED;
    cfg_wdata <= {15'($urandom), armed};
    @(negedge clk);
    cfg_idx <= REG_AWAITED_ID;
    cfg_wdata <= awaited_id;
    @(negedge clk);
    cfg_we <= 1'b0;
    awaited = awaited_id;
  endtask

  // Finish any partial frame with filler bytes, then let all results drain.
  task automatic settle();
    while (!parser_idle)
      send_byte(8'h00);
    in_tvalid <= 1'b0;
    while (results_pending != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic fill_body(input int len, input body_style_t style);
    body_q.delete();
    repeat (len) begin
      case (style)
        BODY_ZERO: body_q.push_back(8'h00);
        BODY_ONES: body_q.push_back(8'hFF);
        default: body_q.push_back(8'($urandom));
      endcase
    end
  endtask

  task automatic send_frame(input logic [15:0] msg_id, input logic [15:0] len,
                            input flaw_t flaw);
    logic [7:0] head [$];
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] second;
    head = {msg_id[7:0], msg_id[15:8], len[7:0], len[15:8]};
    foreach (body_q[i])
      head.push_back(body_q[i]);
    sa = 8'h00;
    sb = 8'h00;
    foreach (head[i]) begin
      sa = sa + head[i];
      sb = sb + sa;
    end
    second = SYNC_TWO;
    if (flaw == FLAW_SYNC) begin
      second = 8'($urandom_range(0, 255));
      if (second == SYNC_TWO)
        second = 8'h00;
    end
    if (flaw == FLAW_CKA)
      sa = sa ^ 8'($urandom_range(1, 255));
    if (flaw == FLAW_CKB)
      sb = sb ^ 8'($urandom_range(1, 255));
    send_byte(SYNC_ONE);
    send_byte(second);
    foreach (head[i])
      send_byte(head[i]);
    send_byte(sa);
    send_byte(sb);
  endtask

  task automatic pvt_frame(input int len, input body_style_t style, input flaw_t flaw);
    fill_body(len, style);
    send_frame(ID_NAV_PVT, 16'(len), flaw);
  endtask

  task automatic ack_frame(input logic is_ack, input logic [15:0] acked, input flaw_t flaw);
    body_q = {acked[7:0], acked[15:8]};
    send_frame(is_ack ? ID_ACK_ACK : ID_ACK_NAK, 16'(ACK_PAYLOAD_BYTES), flaw);
  endtask

  task automatic send_noise(input int n);
    repeat (n)
      send_byte(($urandom_range(0, 4) == 0) ? SYNC_ONE : 8'($urandom));
  endtask

  task automatic random_sequence();
    int r;
    int len;
    logic [15:0] acked;
    logic [15:0] odd_id;
    flaw_t flaw;
    body_style_t style;
    r = $urandom_range(0, 99);
    flaw = ($urandom_range(0, 99) < 85) ? FLAW_NONE : flaw_t'($urandom_range(1, 3));
    case ($urandom_range(0, 3))
      0: acked = 16'($urandom);
      1: acked = awaited ^ (16'd1 << $urandom_range(0, 15));
      default: acked = awaited;
    endcase
    if (r < 30) begin
      ack_frame($urandom_range(0, 1) == 1, acked, flaw);
    end else if (r < 60) begin
      len = ($urandom_range(0, 3) != 0) ? int'(POSITION_PAYLOAD_BYTES) : $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0)
        len = int'(POSITION_PAYLOAD_BYTES) + ($urandom_range(0, 1) == 1 ? 1 : -1);
      case ($urandom_range(0, 19))
        0: style = BODY_ZERO;
        1: style = BODY_ONES;
        default: style = BODY_RANDOM;
      endcase
      pvt_frame(len, style, flaw);
    end else if (r < 70) begin
      odd_id = 16'($urandom);
      if ($urandom_range(0, 1) == 1)
        odd_id[7:0] = ($urandom_range(0, 1) == 1) ? ID_ACK_ACK[7:0] : ID_NAV_PVT[7:0];
      fill_body($urandom_range(0, 4), BODY_RANDOM);
      send_frame(odd_id, 16'(body_q.size()), FLAW_NONE);
    end else if (r < 80) begin
      fill_body($urandom_range(0, 4), BODY_RANDOM);
      send_frame(($urandom_range(0, 1) == 1) ? ID_ACK_ACK : ID_ACK_NAK,
                 16'(body_q.size()), FLAW_NONE);
    end else if (r < 90) begin
      send_noise($urandom_range(1, 6));
    end else begin
      flaw = flaw_t'($urandom_range(1, 3));
      if ($urandom_range(0, 1) == 1)
        ack_frame($urandom_range(0, 1) == 1, acked, flaw);
      else
        pvt_frame(int'(POSITION_PAYLOAD_BYTES), BODY_RANDOM, flaw);
    end
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int phase_count;
    logic cfg_on;
    logic armed_on;
    logic [15:0] id_pick;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    cfg_we = 1'b0;
    cfg_idx = REG_CONFIGURED;
    cfg_wdata = '0;
    rst_n = 1'b0;
    steady = 1'b0;
    awaited = '0;
    bytes_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Not armed: an equal id still reports no match.
    set_config(1'b0, 1'b0, 16'h0000);
    ack_frame(1'b1, 16'h0000, FLAW_NONE);
    ack_frame(1'b0, 16'h0000, FLAW_NONE);
    send_byte(SYNC_ONE);
    send_byte(SYNC_ONE);
    send_byte(SYNC_TWO);
    ack_frame(1'b1, 16'hFFFF, FLAW_NONE);
    pvt_frame(0, BODY_RANDOM, FLAW_NONE);
    pvt_frame(int'(POSITION_PAYLOAD_BYTES), BODY_RANDOM, FLAW_NONE);
    settle();

    set_config(1'b0, 1'b1, 16'hFFFF);
    ack_frame(1'b1, 16'hFFFF, FLAW_NONE);
    ack_frame(1'b0, 16'hFFFF, FLAW_NONE);
    ack_frame(1'b1, 16'hFFFE, FLAW_NONE);
    ack_frame(1'b0, 16'h7FFF, FLAW_NONE);
    ack_frame(1'b1, 16'hFFFF, FLAW_CKA);
    ack_frame(1'b0, 16'hFFFF, FLAW_CKB);
    ack_frame(1'b1, 16'hFFFF, FLAW_SYNC);
    fill_body(3, BODY_RANDOM);
    send_frame(ID_ACK_ACK, 16'd3, FLAW_NONE);
    fill_body(2, BODY_ONES);
    send_frame(16'h0602, 16'd2, FLAW_NONE);
    pvt_frame(5, BODY_ONES, FLAW_NONE);
    settle();

    set_config(1'b1, 1'b0, 16'h0106);
    pvt_frame(int'(POSITION_PAYLOAD_BYTES), BODY_ZERO, FLAW_NONE);
    pvt_frame(int'(POSITION_PAYLOAD_BYTES), BODY_ONES, FLAW_NONE);
    pvt_frame(int'(POSITION_PAYLOAD_BYTES), BODY_RANDOM, FLAW_NONE);
    pvt_frame(int'(POSITION_PAYLOAD_BYTES) + 1, BODY_RANDOM, FLAW_NONE);
    pvt_frame(int'(POSITION_PAYLOAD_BYTES), BODY_RANDOM, FLAW_CKB);
    ack_frame(1'b1, 16'h0106, FLAW_NONE);
    ack_frame(1'b0, 16'h0106, FLAW_NONE);
    settle();

    phase_count = 0;
    while (bytes_sent < MIN_BYTES && phase_count < 100) begin
      steady = ($urandom_range(0, 4) == 0);
      cfg_on = $urandom_range(0, 1);
      armed_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: id_pick = 16'h0000;
        1: id_pick = 16'hFFFF;
        default: id_pick = 16'($urandom);
      endcase
      set_config(cfg_on, armed_on, id_pick);
      repeat ($urandom_range(15, 40))
        random_sequence();
      settle();
      phase_count++;
    end
    steady = 1'b0;

    settle();
    if (mismatches == 0 && results_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
